### design/cdcbs_pkg.sv
// ----------------------------------------------------------------------------
// cdcbs_pkg
// Shared types and constants for the disk shadow-cover pipeline.
// ----------------------------------------------------------------------------
package cdcbs_pkg;

    localparam int CORNERS = 8;
    // length of the valid and flag shift registers along the pipeline
    localparam int DEPTH   = 8;

    // register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    // disk configuration handed to the datapath
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        radius;
    } t_disk;

    // per-corner offset from the center
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
    } t_offs;

endpackage

### design/cdcbs_cfg.sv
// ----------------------------------------------------------------------------
// cdcbs_cfg
// APB register file holding the disk center and radius.
// ----------------------------------------------------------------------------
module cdcbs_cfg import cdcbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_disk       o_disk
);
    t_disk      r_disk;
    logic [1:0] w_idx;
    logic       w_hit;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_hit  = (paddr[1:0] == 2'b00);

    // write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk <= '0;
        end else if (psel && penable && pwrite && w_hit) begin
            case (w_idx)
                REG_CENTER_X: r_disk.cx     <= pwdata;
                REG_CENTER_Y: r_disk.cy     <= pwdata;
                REG_CENTER_Z: r_disk.cz     <= pwdata;
                REG_RADIUS:   r_disk.radius <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_CENTER_X: prdata = r_disk.cx;
            REG_CENTER_Y: prdata = r_disk.cy;
            REG_CENTER_Z: prdata = r_disk.cz;
            REG_RADIUS:   prdata = {1'b0, r_disk.radius};
            default:      prdata = '0;
        endcase
        if (!w_hit) prdata = '0;
    end

    assign o_disk = r_disk;
endmodule

### design/cdcbs_corner.sv
// ----------------------------------------------------------------------------
// cdcbs_corner
// Pipelined test of one corner: dot <= 0 and |d x s|^2 <= r^2 |s|^2.
// Stages: products, cross/dot, partial squares (17/32-bit split), squares,
// compare.
// ----------------------------------------------------------------------------
module cdcbs_corner import cdcbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_offs              i_offs,
    input  logic signed [15:0] i_sx,
    input  logic signed [15:0] i_sy,
    input  logic signed [15:0] i_sz,
    input  logic [97:0]        i_limit,
    output logic               o_pass
);
    // stage 1: partial products d*s
    logic signed [48:0] r_p [6];
    logic signed [48:0] r_q [3];
    logic [97:0]        r_lim1;
    // stage 2: cross and dot
    logic signed [49:0] r_cr [3];
    logic               r_dotok;
    logic [97:0]        r_lim2;
    // stage 3: partial squares of the cross magnitudes
    logic [63:0]        r_ll [3];
    logic [48:0]        r_hl [3];
    logic [33:0]        r_hh [3];
    logic               r_dotok3;
    logic [97:0]        r_lim3;
    // stage 4: full squares
    logic [97:0]        r_sq [3];
    logic               r_dotok4;
    logic [97:0]        r_lim4;
    // stage 5: result
    logic               r_pass;
    logic [48:0]        w_m [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_m[k] = r_cr[k][49] ? 49'(-r_cr[k]) : r_cr[k][48:0];
        end
    end

    // advance all stages together when enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_offs.dy * i_sz;
            r_p[1] <= i_offs.dz * i_sy;
            r_p[2] <= i_offs.dz * i_sx;
            r_p[3] <= i_offs.dx * i_sz;
            r_p[4] <= i_offs.dx * i_sy;
            r_p[5] <= i_offs.dy * i_sx;
            r_q[0] <= i_offs.dx * i_sx;
            r_q[1] <= i_offs.dy * i_sy;
            r_q[2] <= i_offs.dz * i_sz;
            r_lim1 <= i_limit;

            r_cr[0] <= 50'(r_p[0]) - 50'(r_p[1]);
            r_cr[1] <= 50'(r_p[2]) - 50'(r_p[3]);
            r_cr[2] <= 50'(r_p[4]) - 50'(r_p[5]);
            r_dotok <= (51'(r_q[0]) + 51'(r_q[1]) + 51'(r_q[2])) <= 51'sd0;
            r_lim2  <= r_lim1;

            // split each magnitude into a high 17-bit and a low 32-bit part
            for (int k = 0; k < 3; k++) begin
                r_ll[k] <= 64'(w_m[k][31:0]) * 64'(w_m[k][31:0]);
                r_hl[k] <= 49'(w_m[k][48:32]) * 49'(w_m[k][31:0]);
                r_hh[k] <= 34'(w_m[k][48:32]) * 34'(w_m[k][48:32]);
            end
            r_dotok3 <= r_dotok;
            r_lim3   <= r_lim2;

            // recombine: h^2 << 64 + 2hl << 32 + l^2
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (98'(r_hh[k]) << 64) + (98'(r_hl[k]) << 33) + 98'(r_ll[k]);
            end
            r_dotok4 <= r_dotok3;
            r_lim4   <= r_lim3;

            r_pass <= r_dotok4 &&
                      ((100'(r_sq[0]) + 100'(r_sq[1]) + 100'(r_sq[2])) <= 100'(r_lim4));
        end
    end

    assign o_pass = r_pass;
endmodule

### design/check_disk_covers_box_shadow.sv
// ----------------------------------------------------------------------------
// check_disk_covers_box_shadow
// Tests whether a configured disk covers the shadow of an axis-aligned box.
// ----------------------------------------------------------------------------
// Usage: program center and radius over APB while idle (pready always high).
// Each input transfer carries a box and a sun direction; each produces one
// output transfer with covered and bad_direction.
// Pipeline: stage 0 forms corner offsets and r^2, stage 1 forms r^2*|s|^2,
// then five stages per corner (products, cross/dot, partial squares,
// squares, compare), with all eight corners in parallel lanes, and a final
// output register.
// One item is accepted per cycle while the output register is not stalled.
// The pipeline moves only when the output register is empty or being taken,
// so a stall at the receiver freezes every stage and loses nothing.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module check_disk_covers_box_shadow import cdcbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    input  logic signed [15:0] i_sun_dir_x,
    input  logic signed [15:0] i_sun_dir_y,
    input  logic signed [15:0] i_sun_dir_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_covered,
    output logic               o_bad_direction
);
    t_disk              w_disk;
    logic               w_en;
    logic [DEPTH-1:0]   r_vld;
    logic [DEPTH-1:0]   r_bad;
    t_offs              r_offs [CORNERS];
    logic signed [15:0] r_s [3][2];
    logic [61:0]        r_r2;
    logic [32:0]        r_s2;
    logic [97:0]        r_lim;
    logic [63:0]        w_lim_hi;
    logic [63:0]        w_lim_lo;
    logic [CORNERS-1:0] w_pass;
    logic               w_zero;

    cdcbs_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_disk(w_disk)
    );

    assign w_en    = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = w_en;
    assign w_zero  = (i_sun_dir_x == '0) && (i_sun_dir_y == '0) && (i_sun_dir_z == '0);

    // valid and zero-direction flags travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bad <= {r_bad[DEPTH-2:0], w_zero};
        end
    end

    // split r^2 * |s|^2 into two 31x33 products
    assign w_lim_hi = 64'(r_r2[61:31]) * 64'(r_s2);
    assign w_lim_lo = 64'(r_r2[30:0]) * 64'(r_s2);

    // stage 0: offsets, r^2, |s|^2; stage 1: limit
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < CORNERS; c++) begin
                r_offs[c].dx <= (c[0] ? 33'(i_box_max_x) : 33'(i_box_min_x)) - 33'(w_disk.cx);
                r_offs[c].dy <= (c[1] ? 33'(i_box_max_y) : 33'(i_box_min_y)) - 33'(w_disk.cy);
                r_offs[c].dz <= (c[2] ? 33'(i_box_max_z) : 33'(i_box_min_z)) - 33'(w_disk.cz);
            end
            r_s[0][0] <= i_sun_dir_x;
            r_s[1][0] <= i_sun_dir_y;
            r_s[2][0] <= i_sun_dir_z;
            r_r2 <= 62'(w_disk.radius) * 62'(w_disk.radius);
            r_s2 <= 33'(32'(i_sun_dir_x) * 32'(i_sun_dir_x))
                  + 33'(32'(i_sun_dir_y) * 32'(i_sun_dir_y))
                  + 33'(32'(i_sun_dir_z) * 32'(i_sun_dir_z));
            r_lim <= (98'(w_lim_hi) << 31) + 98'(w_lim_lo);
            for (int k = 0; k < 3; k++) r_s[k][1] <= r_s[k][0];
        end
    end

    // offsets are registered once more so the corner lanes receive them together with the limit
    t_offs r_offs1 [CORNERS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < CORNERS; c++) r_offs1[c] <= r_offs[c];
        end
    end

    for (genvar g = 0; g < CORNERS; g++) begin : g_lane
        cdcbs_corner u_corner (
            .i_clk(i_clk), .i_en(w_en), .i_offs(r_offs1[g]),
            .i_sx(r_s[0][1]), .i_sy(r_s[1][1]), .i_sz(r_s[2][1]),
            .i_limit(r_lim), .o_pass(w_pass[g])
        );
    end

    // final output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_covered <= r_bad[DEPTH-2] || (&w_pass);
        end
    end

    assign o_valid         = r_vld[DEPTH-1];
    assign o_bad_direction = r_bad[DEPTH-1];

    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_covered)) else $error("output changed");
    // ready only drops while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid) else $error("ready low without result");
    // a bad direction always reads as covered
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_direction |-> o_covered) else $error("bad dir not covered");
endmodule

### tb/shadow_cover_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shadow_cover_checker
// Watches the box and result channels and the APB write port, computes the
// expected covered/bad_direction flags and compares them with the block.
// ----------------------------------------------------------------------------
module shadow_cover_checker import cdcbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    input  logic signed [15:0] i_sun_dir_x,
    input  logic signed [15:0] i_sun_dir_y,
    input  logic signed [15:0] i_sun_dir_z,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic               o_covered,
    input  logic               o_bad_direction,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic covered;
        logic bad_dir;
    } t_flags;

    t_flags             flags_q[$];
    logic signed [31:0] ctr[3];
    logic [30:0]        rad;

    // covered test over all eight corners, exact wide integer arithmetic
    function automatic t_flags cover_flags(input logic signed [31:0] bmin[3],
                                           input logic signed [31:0] bmax[3],
                                           input logic signed [15:0] dir[3]);
        t_flags                  f;
        logic signed [63:0]      d[3];
        logic signed [63:0]      s[3];
        logic signed [63:0]      dot;
        logic signed [63:0]      cr[3];
        logic [127:0]            lim;
        logic [127:0]            sum;
        logic [63:0]             s2;
        f.covered = 1'b1;
        f.bad_dir = 1'b0;
        for (int k = 0; k < 3; k++) s[k] = dir[k];
        if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
            f.bad_dir = 1'b1;
            return f;
        end
        s2  = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        lim = 128'(rad) * 128'(rad) * 128'(s2);
        for (int c = 0; c < CORNERS; c++) begin
            for (int k = 0; k < 3; k++)
                d[k] = 64'(((c >> k) & 1) ? bmax[k] : bmin[k]) - 64'(ctr[k]);
            dot = d[0] * s[0] + d[1] * s[1] + d[2] * s[2];
            if (dot > 0) f.covered = 1'b0;
            cr[0] = d[1] * s[2] - d[2] * s[1];
            cr[1] = d[2] * s[0] - d[0] * s[2];
            cr[2] = d[0] * s[1] - d[1] * s[0];
            sum = 0;
            for (int k = 0; k < 3; k++)
                sum += 128'(cr[k]) * 128'(cr[k]);
            if (sum > lim) f.covered = 1'b0;
        end
        return f;
    endfunction

    assign o_pending = flags_q.size();

    always @(posedge i_clk) begin
        t_flags exp_f;
        if (!i_rst_n) begin
            ctr          = '{default: '0};
            rad          = '0;
            flags_q      = {};
            o_fail_count = 0;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CENTER_X: ctr[0] = pwdata;
                    REG_CENTER_Y: ctr[1] = pwdata;
                    REG_CENTER_Z: ctr[2] = pwdata;
                    REG_RADIUS:   rad    = pwdata[30:0];
                    default: ;
                endcase
            end
            // compare result transfer with the oldest expectation
            if (o_valid && i_ready) begin
                if (flags_q.size() == 0) begin
                    $display("%0t: unexpected result covered=%0b bad=%0b",
                             $time, o_covered, o_bad_direction);
                    o_fail_count++;
                end else begin
                    exp_f = flags_q.pop_front();
                    if (exp_f.covered !== o_covered) begin
                        $display("%0t: covered expected %0b actual %0b",
                                 $time, exp_f.covered, o_covered);
                        o_fail_count++;
                    end
                    if (exp_f.bad_dir !== o_bad_direction) begin
                        $display("%0t: bad_direction expected %0b actual %0b",
                                 $time, exp_f.bad_dir, o_bad_direction);
                        o_fail_count++;
                    end
                end
            end
            // predict on each accepted box transfer
            if (i_valid && o_ready)
                flags_q.push_back(cover_flags(
                    '{i_box_min_x, i_box_min_y, i_box_min_z},
                    '{i_box_max_x, i_box_max_y, i_box_max_z},
                    '{i_sun_dir_x, i_sun_dir_y, i_sun_dir_z}));
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives boxes, sun directions and disk settings into the shadow-cover
// block with random idling, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench import cdcbs_pkg::*;;

    localparam int WATCHDOG = 2000;
    localparam int LATENCY  = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_box_min_x = '0, i_box_min_y = '0, i_box_min_z = '0;
    logic signed [31:0] i_box_max_x = '0, i_box_max_y = '0, i_box_max_z = '0;
    logic signed [15:0] i_sun_dir_x = '0, i_sun_dir_y = '0, i_sun_dir_z = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_covered;
    logic               o_bad_direction;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 no_idle = 1'b0;

    check_disk_covers_box_shadow u_dut (.*);

    shadow_cover_checker u_chk (
        .o_fail_count(fail_count), .o_pending(pending), .*
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stalls at random, except in the no-idle stretch
    always @(negedge i_clk)
        i_ready <= no_idle || ($urandom_range(99) >= 9);

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            idle_cycles = 0;
        else if (i_rst_n && ++idle_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_disk(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [30:0] r);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, {1'b0, r});
    endtask

    // drop valid and drain the pipeline before touching the registers
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // send one box; valid stays up until accepted and drops only when idling
    task automatic send_box(input logic [31:0] mn[3], input logic [31:0] mx[3],
                            input logic [15:0] dir[3]);
        if (!no_idle)
            while ($urandom_range(99) < 9) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_valid <= 1'b1;
        i_box_min_x <= mn[0]; i_box_min_y <= mn[1]; i_box_min_z <= mn[2];
        i_box_max_x <= mx[0]; i_box_max_y <= mx[1]; i_box_max_z <= mx[2];
        i_sun_dir_x <= dir[0]; i_sun_dir_y <= dir[1]; i_sun_dir_z <= dir[2];
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    // random boxes: fully random corners, or a random base with a span of up to 2^20
    task automatic random_boxes(input int count);
        logic [31:0] mn[3], mx[3], base, span;
        logic [15:0] dir[3];
        int          mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(9);
            for (int k = 0; k < 3; k++) begin
                dir[k] = ($urandom_range(3) == 0) ? 16'($urandom)
                         : 16'($signed($urandom_range(8)) - 4);
                if (mode == 0) begin
                    mn[k] = $urandom; mx[k] = $urandom;
                end else begin
                    base  = rand_coord(mode % 3);
                    span  = $urandom_range(1 << ($urandom_range(20)));
                    mn[k] = base; mx[k] = base + span;
                end
            end
            if ($urandom_range(30) == 0) dir = '{16'd0, 16'd0, 16'd0};
            send_box(mn, mx, dir);
        end
    endtask

    initial begin
        logic [31:0] z3[3];
        logic [31:0] hi3[3];
        logic [31:0] lo3[3];
        z3  = '{32'd0, 32'd0, 32'd0};
        hi3 = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        lo3 = '{32'h80000000, 32'h80000000, 32'h80000000};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset disk (zero radius, origin)
        send_box(z3, z3, '{16'd0, 16'd0, 16'd0});
        send_box(z3, z3, '{16'd0, 16'd0, 16'h8000});
        send_box(lo3, hi3, '{16'h7fff, 16'h8000, 16'd1});
        send_box(hi3, lo3, '{16'hffff, 16'hffff, 16'hffff});
        drain();
        set_disk(32'h7fffffff, 32'h80000000, 32'd0, 31'h7fffffff);
        send_box(lo3, hi3, '{16'h8000, 16'h8000, 16'h8000});
        send_box(lo3, hi3, '{16'h7fff, 16'h7fff, 16'h7fff});
        send_box(z3, z3, '{16'd0, 16'd1, 16'd0});
        send_box(hi3, hi3, '{16'h8000, 16'd0, 16'd0});
        send_box(lo3, lo3, '{16'd0, 16'd0, 16'd0});
        drain();
        set_disk(32'd0, 32'd0, 32'h0001_0000, 31'h0002_0000);
        send_box('{32'hffff_0000, 32'hffff_0000, 32'hfff0_0000},
                 '{32'h0001_0000, 32'h0001_0000, 32'hffff_0000},
                 '{16'd0, 16'd0, 16'd1});
        send_box('{32'hffff_0000, 32'hffff_0000, 32'h0002_0000},
                 '{32'h0001_0000, 32'h0001_0000, 32'h0003_0000},
                 '{16'd0, 16'd0, 16'hffff});
        send_box('{32'hfffc_0000, 32'd0, 32'd0}, '{32'h0004_0000, 32'd0, 32'd0},
                 '{16'd0, 16'd0, 16'd1});
        drain();

        // random phases across several disk settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_disk(32'd0, 32'd0, 32'd0, 31'h0010_0000);
                1: set_disk($urandom, $urandom, $urandom, 31'($urandom));
                2: set_disk(32'h0005_0000, 32'hfffb_0000, 32'd0, 31'h0400_0000);
                3: set_disk(32'd0, 32'd0, 32'd0, 31'h7fffffff);
                default: set_disk(rand_coord(1), rand_coord(1), rand_coord(1),
                                  31'($urandom_range(32'h0100_0000)));
            endcase
            no_idle = (ph == 3);
            random_boxes(100);
            // hold off until all results are back
            i_valid <= 1'b0;
            while (pending != 0) @(negedge i_clk);
            random_boxes(105);
            no_idle = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
design/cdcbs_pkg.sv
design/cdcbs_cfg.sv
design/cdcbs_corner.sv
design/check_disk_covers_box_shadow.sv
tb/shadow_cover_checker.sv
tb/testbench.sv
